FILE: sv/tlsh_pkg.sv
`default_nettype none

package tlsh_pkg;

  localparam int unsigned RANDOM_BYTES = 32;
  localparam int unsigned MIN_BODY     = RANDOM_BYTES + 2;
  localparam int unsigned IDX_W        = $clog2(RANDOM_BYTES);
  localparam int unsigned CIDX_W       = $clog2(MIN_BODY + 1);
  localparam int unsigned LEFT_W       = $clog2(RANDOM_BYTES + 1);

  localparam logic [7:0] HANDSHAKE_RECORD = 8'd22;

  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_WANTED_TYPE = 1'b0;
  localparam logic [7:0]  WANTED_TYPE_RESET = 8'd1;

  typedef enum logic [2:0] {
    PH_RECORD_HEADER,
    PH_RECORD_SKIP,
    PH_MESSAGE_HEADER,
    PH_MESSAGE_BODY,
    PH_CAPTURE,
    PH_DONE
  } phase_t;

  // Phase that follows a message boundary inside a handshake record.
  function automatic phase_t next_message(input logic [15:0] rem);
    phase_t ph;
    ph = (rem < 16'd4) ? PH_RECORD_SKIP : PH_MESSAGE_HEADER;
    return ph;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tlsh_if.sv
`default_nettype none

interface tlsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tlsh_out_if import tlsh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       random_byte;
  logic [IDX_W-1:0] byte_index;
  logic             found;
  logic             last_result;

  modport source (output valid, output random_byte, output byte_index, output found,
                  output last_result, input ready);
  modport sink   (input valid, input random_byte, input byte_index, input found,
                  input last_result, output ready);
endinterface

`default_nettype wire

FILE: sv/tlsh_ram.sv
`default_nettype none

module tlsh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tls_hello_random_extractor_unit.sv
// Channel   Dir  Payload                                       Handshake
// in_ch     in   data_byte[7:0], end_of_buffer                 valid/ready
// out_ch    out  random_byte[7:0], byte_index[4:0], found,     valid/ready
//                last_result
// cfg       in   APB write/read of wanted_type at byte 0       psel/penable, pready=1
//
// One byte per cycle is parsed; header and length tracking sit in registers and
// the captured random goes into a 32x8 RAM with a registered read.
// The request carrying end_of_buffer starts a burst of 32 results (or one
// not-found result), read out of the RAM at one per cycle unless the output stalls;
// input is held off from that request until the last RAM read has moved to the output register.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module tls_hello_random_extractor_unit import tlsh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tlsh_in_if.sink                in_ch,
  tlsh_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  logic [7:0] wanted_type_r;

  phase_t        phase_r, phase_nxt;
  logic [2:0]    hcnt_r, hcnt_nxt;
  logic [23:0]   hshift_r, hshift_nxt;
  logic          is_hs_r, is_hs_nxt;
  logic [15:0]   rrem_r, rrem_nxt;
  logic [15:0]   mrem_r, mrem_nxt;
  logic [CIDX_W-1:0] cidx_r, cidx_nxt;
  logic          cpend_r, cpend_nxt;
  logic          found_r, found_nxt;
  logic          tmatch_r, tmatch_nxt;

  logic [LEFT_W-1:0] iss_left_r, iss_left_nxt;
  logic [IDX_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic              iss_found_r, iss_found_nxt;

  logic              st_vld_r, st_vld_nxt;
  logic [IDX_W-1:0]  st_idx_r;
  logic              st_found_r;
  logic              st_last_r;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_found_r;
  logic              out_last_r;

  logic              acc;
  logic [7:0]        b;
  logic [23:0]       shifted;
  logic [15:0]       rdec;
  logic [23:0]       msg_len;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CIDX_W-1:0] cidx_off;
  logic [7:0]        ram_rdata;
  logic              issue;
  logic              adv;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_WANTED_TYPE) begin
      prdata = {24'd0, wanted_type_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r <= WANTED_TYPE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WANTED_TYPE) begin
      wanted_type_r <= pwdata[7:0];
    end
  end

  // Input is held while the RAM still has reads to serve for the last run.
  assign in_ch.ready = (iss_left_r == '0) && !st_vld_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign shifted     = {hshift_r[15:0], b};
  assign rdec        = rrem_r - 16'd1;
  assign msg_len     = shifted;
  assign cidx_off    = cidx_r - CIDX_W'(2);
  assign ram_waddr   = cidx_off[IDX_W-1:0];
  assign ram_we      = acc && (phase_r == PH_CAPTURE) && (cidx_r >= CIDX_W'(2));

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    hshift_nxt = hshift_r;
    is_hs_nxt  = is_hs_r;
    rrem_nxt   = rrem_r;
    mrem_nxt   = mrem_r;
    cidx_nxt   = cidx_r;
    cpend_nxt  = cpend_r;
    found_nxt  = found_r;
    tmatch_nxt = tmatch_r;

    if (acc) begin
      case (phase_r)
        PH_DONE: begin
        end
        PH_RECORD_HEADER: begin
          hshift_nxt = shifted;
          hcnt_nxt   = hcnt_r + 3'd1;
          if (hcnt_r == 3'd0) begin
            is_hs_nxt = (b == HANDSHAKE_RECORD);
          end
          if (hcnt_r == 3'd4) begin
            rrem_nxt   = shifted[15:0];
            hcnt_nxt   = 3'd0;
            hshift_nxt = 24'd0;
            if (shifted[15:0] == 16'd0) begin
              phase_nxt = PH_RECORD_HEADER;
            end else if (is_hs_r) begin
              phase_nxt = next_message(shifted[15:0]);
            end else begin
              phase_nxt = PH_RECORD_SKIP;
            end
          end
        end
        default: begin
          rrem_nxt = rdec;
          case (phase_r)
            PH_MESSAGE_HEADER: begin
              hcnt_nxt = hcnt_r + 3'd1;
              if (hcnt_r == 3'd0) begin
                tmatch_nxt = (b == wanted_type_r);
                hshift_nxt = 24'd0;
              end else begin
                hshift_nxt = shifted;
              end
              if (hcnt_r == 3'd3) begin
                hcnt_nxt   = 3'd0;
                hshift_nxt = 24'd0;
                if (msg_len > {8'd0, rdec}) begin
                  phase_nxt = PH_RECORD_SKIP;
                end else if (tmatch_r && msg_len >= 24'(MIN_BODY)) begin
                  cidx_nxt  = '0;
                  phase_nxt = PH_CAPTURE;
                end else if (msg_len == 24'd0) begin
                  phase_nxt = next_message(rdec);
                end else begin
                  mrem_nxt  = msg_len[15:0];
                  phase_nxt = PH_MESSAGE_BODY;
                end
              end
            end
            PH_MESSAGE_BODY: begin
              mrem_nxt = mrem_r - 16'd1;
              if (mrem_r == 16'd1) begin
                hcnt_nxt   = 3'd0;
                hshift_nxt = 24'd0;
                phase_nxt  = next_message(rdec);
              end
            end
            PH_CAPTURE: begin
              cidx_nxt = cidx_r + CIDX_W'(1);
              if (cidx_r == CIDX_W'(MIN_BODY - 1)) begin
                cpend_nxt = 1'b1;
                phase_nxt = PH_RECORD_SKIP;
              end
            end
            default: begin
            end
          endcase
          if (rdec == 16'd0) begin
            hcnt_nxt   = 3'd0;
            hshift_nxt = 24'd0;
            if (cpend_nxt) begin
              found_nxt = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_RECORD_HEADER;
            end
          end
        end
      endcase

      if (in_ch.end_of_buffer) begin
        phase_nxt  = PH_RECORD_HEADER;
        hcnt_nxt   = 3'd0;
        hshift_nxt = 24'd0;
        is_hs_nxt  = 1'b0;
        rrem_nxt   = 16'd0;
        mrem_nxt   = 16'd0;
        cidx_nxt   = '0;
        cpend_nxt  = 1'b0;
        found_nxt  = 1'b0;
        tmatch_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RECORD_HEADER;
      hcnt_r   <= 3'd0;
      hshift_r <= 24'd0;
      is_hs_r  <= 1'b0;
      rrem_r   <= 16'd0;
      mrem_r   <= 16'd0;
      cidx_r   <= '0;
      cpend_r  <= 1'b0;
      found_r  <= 1'b0;
      tmatch_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      hshift_r <= hshift_nxt;
      is_hs_r  <= is_hs_nxt;
      rrem_r   <= rrem_nxt;
      mrem_r   <= mrem_nxt;
      cidx_r   <= cidx_nxt;
      cpend_r  <= cpend_nxt;
      found_r  <= found_nxt;
      tmatch_r <= tmatch_nxt;
    end
  end

  tlsh_ram #(
    .WIDTH(8),
    .DEPTH(RANDOM_BYTES)
  ) u_random_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(b),
    .re   (issue),
    .raddr(iss_idx_r),
    .rdata(ram_rdata)
  );

  // Result burst: issue reads, one stage for RAM latency, then the output register.
  assign adv   = st_vld_r && (!out_valid_r || out_ch.ready);
  assign issue = (iss_left_r != '0) && (!st_vld_r || adv);

  // Found status of the run including the byte being taken now.
  function automatic logic found_nxt_run();
    logic f;
    f = (phase_r == PH_DONE) || found_r ||
        ((phase_r != PH_RECORD_HEADER) && (rdec == 16'd0) &&
         (cpend_r || ((phase_r == PH_CAPTURE) && (cidx_r == CIDX_W'(MIN_BODY - 1)))));
    return f;
  endfunction

  always_comb begin
    iss_left_nxt  = iss_left_r;
    iss_idx_nxt   = iss_idx_r;
    iss_found_nxt = iss_found_r;
    if (issue) begin
      iss_left_nxt = iss_left_r - LEFT_W'(1);
      iss_idx_nxt  = iss_idx_r + IDX_W'(1);
    end
    if (acc && in_ch.end_of_buffer) begin
      iss_left_nxt  = found_nxt_run() ? LEFT_W'(RANDOM_BYTES) : LEFT_W'(1);
      iss_idx_nxt   = '0;
      iss_found_nxt = found_nxt_run();
    end

    st_vld_nxt = st_vld_r;
    if (issue) begin
      st_vld_nxt = 1'b1;
    end else if (adv) begin
      st_vld_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_left_r  <= '0;
      st_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      iss_left_r  <= iss_left_nxt;
      st_vld_r    <= st_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r   <= iss_idx_nxt;
    iss_found_r <= iss_found_nxt;
    if (issue) begin
      st_idx_r   <= iss_idx_r;
      st_found_r <= iss_found_r;
      st_last_r  <= (iss_left_r == LEFT_W'(1));
    end
    if (adv) begin
      out_byte_r  <= st_found_r ? ram_rdata : 8'd0;
      out_idx_r   <= st_found_r ? st_idx_r : '0;
      out_found_r <= st_found_r;
      out_last_r  <= st_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_byte = out_byte_r;
  assign out_ch.byte_index  = out_idx_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.last_result = out_last_r;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tlsh_pkg::*;

  localparam logic [7:0] CLIENT_HELLO = 8'd1;
  localparam logic [7:0] SERVER_HELLO = 8'd2;
  localparam logic [7:0] APP_DATA_REC = 8'd23;
  localparam logic [ADDR_W-1:0] WANTED_ADDR = ADDR_W'(4 * REG_WANTED_TYPE);
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } byte_req_t;

  typedef struct packed {
    logic [7:0]       rnd_byte;
    logic [IDX_W-1:0] idx;
    logic             found;
    logic             last_res;
  } rand_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tlsh_in_if  in_ch ();
  tlsh_out_if out_ch ();

  tls_hello_random_extractor_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_req_t  byte_q[$];
  rand_res_t  random_exp_q[$];
  logic [7:0] bytes_q[$];
  int         errs = 0;
  int         acc_cnt = 0;
  int         cyc = 0;
  int         hold_at = 32'h7fffffff;
  int         hold_left = 0;
  bit         hold_used = 1'b0;
  int         calm_lo = 0;
  int         calm_hi = 0;
  logic       calm;

  assign calm = (acc_cnt >= calm_lo) && (acc_cnt < calm_hi);

  // Scanner state mirrored from the block.
  phase_t      scan_ph;
  logic [2:0]  hdr_cnt;
  logic [23:0] hdr_sr;
  logic        in_hs_rec;
  logic [15:0] rec_left;
  logic [15:0] body_left;
  logic [5:0]  cap_pos;
  logic [7:0]  rnd_mem [RANDOM_BYTES];
  logic        cap_done;
  logic        rnd_valid;
  logic        type_hit;
  logic [7:0]  want_m;

  task automatic clear_scan();
    scan_ph   = PH_RECORD_HEADER;
    hdr_cnt   = '0;
    hdr_sr    = '0;
    in_hs_rec = 1'b0;
    rec_left  = '0;
    body_left = '0;
    cap_pos   = '0;
    cap_done  = 1'b0;
    rnd_valid = 1'b0;
    type_hit  = 1'b0;
  endtask

  task automatic msg_boundary();
    hdr_cnt = '0;
    hdr_sr  = '0;
    scan_ph = (rec_left < 16'd4) ? PH_RECORD_SKIP : PH_MESSAGE_HEADER;
  endtask

  // Advance the scan by one accepted byte and queue the results it causes.
  task automatic scan_byte(input logic [7:0] b, input logic eob);
    logic [23:0] mlen;
    rand_res_t   r;
    if (scan_ph == PH_RECORD_HEADER) begin
      hdr_sr  = {hdr_sr[15:0], b};
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt == 3'd1) in_hs_rec = (b == HANDSHAKE_RECORD);
      if (hdr_cnt == 3'd5) begin
        rec_left = hdr_sr[15:0];
        hdr_cnt  = '0;
        hdr_sr   = '0;
        if (rec_left == 16'd0) scan_ph = PH_RECORD_HEADER;
        else if (in_hs_rec) msg_boundary();
        else scan_ph = PH_RECORD_SKIP;
      end
    end else if (scan_ph != PH_DONE) begin
      rec_left = rec_left - 16'd1;
      case (scan_ph)
        PH_MESSAGE_HEADER: begin
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd1) begin
            type_hit = (b == want_m);
            hdr_sr   = '0;
          end else begin
            hdr_sr = {hdr_sr[15:0], b};
          end
          if (hdr_cnt == 3'd4) begin
            mlen    = hdr_sr;
            hdr_cnt = '0;
            hdr_sr  = '0;
            if (mlen > {8'd0, rec_left}) begin
              scan_ph = PH_RECORD_SKIP;
            end else if (type_hit && mlen >= MIN_BODY) begin
              cap_pos = '0;
              scan_ph = PH_CAPTURE;
            end else if (mlen == 24'd0) begin
              msg_boundary();
            end else begin
              body_left = mlen[15:0];
              scan_ph   = PH_MESSAGE_BODY;
            end
          end
        end
        PH_MESSAGE_BODY: begin
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) msg_boundary();
        end
        PH_CAPTURE: begin
          if (cap_pos >= 6'd2 && cap_pos < 2 + RANDOM_BYTES) rnd_mem[IDX_W'(cap_pos - 6'd2)] = b;
          cap_pos = cap_pos + 6'd1;
          if (cap_pos >= MIN_BODY) begin
            cap_done = 1'b1;
            scan_ph  = PH_RECORD_SKIP;
          end
        end
        default: ;
      endcase
      if (rec_left == 16'd0) begin
        hdr_cnt = '0;
        hdr_sr  = '0;
        if (cap_done) begin
          rnd_valid = 1'b1;
          scan_ph   = PH_DONE;
        end else begin
          scan_ph = PH_RECORD_HEADER;
        end
      end
    end
    if (eob) begin
      if (rnd_valid) begin
        for (int k = 0; k < RANDOM_BYTES; k++) begin
          r.rnd_byte = rnd_mem[k];
          r.idx      = IDX_W'(k);
          r.found    = 1'b1;
          r.last_res = (k == RANDOM_BYTES - 1);
          random_exp_q.push_back(r);
        end
      end else begin
        r = '0;
        r.last_res = 1'b1;
        random_exp_q.push_back(r);
      end
      clear_scan();
    end
  endtask

  // Input side: offer queued bytes and fold every accepted one into the scan.
  always @(posedge clk) begin
    byte_req_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(in_ch.data_byte, in_ch.end_of_buffer);
        acc_cnt <= acc_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          req = byte_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= req.data;
          in_ch.end_of_buffer <= req.eob;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string fname, int unsigned exp_v, int unsigned got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, got_v);
      errs++;
    end
  endfunction

  // Result side: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rand_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (random_exp_q.size() == 0) begin
          $error("unexpected result: random_byte %0h byte_index %0d found %0b last_result %0b",
                 out_ch.random_byte, out_ch.byte_index, out_ch.found, out_ch.last_result);
          errs++;
        end else begin
          e = random_exp_q.pop_front();
          check_field("random_byte", e.rnd_byte, out_ch.random_byte);
          check_field("byte_index", e.idx, out_ch.byte_index);
          check_field("found", e.found, out_ch.found);
          check_field("last_result", e.last_res, out_ch.last_result);
        end
      end
      out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 18);
    end
  end

  // One long hold-off of the result side while input keeps coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_used && acc_cnt >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tls_hello_random_extractor_unit: mismatch");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (byte_q.size() != 0 || in_ch.valid || random_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write wanted_type, then read it back.
  task automatic write_wanted(input logic [7:0] v);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= WANTED_ADDR;
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want_m = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("wanted_type", v, prdata[7:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic put_noise(input int n);
    for (int i = 0; i < n; i++) bytes_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_rec_hdr(input logic [7:0] rtype, input logic [15:0] len);
    bytes_q.push_back(rtype);
    bytes_q.push_back(8'h03);
    bytes_q.push_back(8'h03);
    bytes_q.push_back(len[15:8]);
    bytes_q.push_back(len[7:0]);
  endtask

  task automatic put_hs_msg(input logic [7:0] mtype, input logic [23:0] len, input int nbody);
    bytes_q.push_back(mtype);
    bytes_q.push_back(len[23:16]);
    bytes_q.push_back(len[15:8]);
    bytes_q.push_back(len[7:0]);
    put_noise(nbody);
  endtask

  task automatic put_hello_record(input logic [7:0] mtype);
    put_rec_hdr(HANDSHAKE_RECORD, 16'(MIN_BODY + 4));
    put_hs_msg(mtype, 24'(MIN_BODY), MIN_BODY);
  endtask

  // A handshake record of filler messages, optionally holding the hello.
  task automatic put_hs_record(input bit with_hello, input logic [7:0] htype);
    int          start;
    int          nfill;
    int          blen;
    logic [15:0] len;
    start = bytes_q.size();
    put_rec_hdr(HANDSHAKE_RECORD, 16'd0);
    nfill = $urandom_range(2);
    for (int i = 0; i < nfill; i++) begin
      blen = $urandom_range(12);
      put_hs_msg(8'($urandom_range(255)), 24'(blen), blen);
    end
    if (with_hello) begin
      blen = $urandom_range(MIN_BODY + 6, MIN_BODY);
      put_hs_msg(htype, 24'(blen), blen);
    end
    if ($urandom_range(3) == 0) put_noise($urandom_range(3, 1));
    len = 16'(bytes_q.size() - start - 5);
    bytes_q[start + 3] = len[15:8];
    bytes_q[start + 4] = len[7:0];
  endtask

  task automatic flush_buffer(input bit with_eob);
    byte_req_t req;
    while (bytes_q.size() != 0) begin
      req.data = bytes_q.pop_front();
      req.eob  = with_eob && (bytes_q.size() == 0);
      byte_q.push_back(req);
    end
  endtask

  initial begin
    int         rnd_bytes;
    int         nbuf;
    int         kind;
    int         nrec;
    int         hello_at;
    int         brk;
    int         n;
    logic [7:0] rtype;
    logic [7:0] v;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready = 1'b0;
    want_m = WANTED_TYPE_RESET;
    clear_scan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Basic client hello, random bytes at both extremes.
    put_rec_hdr(HANDSHAKE_RECORD, 16'(MIN_BODY + 4));
    put_hs_msg(CLIENT_HELLO, 24'(MIN_BODY), 0);
    for (int k = 0; k < MIN_BODY; k++) bytes_q.push_back(k[0] ? 8'hFF : 8'h00);
    flush_buffer(1'b1);
    // Single byte, then a header cut short.
    bytes_q.push_back(HANDSHAKE_RECORD);
    flush_buffer(1'b1);
    put_noise(3);
    bytes_q[0] = HANDSHAKE_RECORD;
    flush_buffer(1'b1);
    // Hello captured but its record is truncated by the end of the buffer.
    put_rec_hdr(HANDSHAKE_RECORD, 16'd60);
    put_hs_msg(CLIENT_HELLO, 24'(MIN_BODY), MIN_BODY);
    flush_buffer(1'b1);
    // Non-handshake record, empty record, record too short for a header.
    put_rec_hdr(APP_DATA_REC, 16'd3);
    put_noise(3);
    put_rec_hdr(HANDSHAKE_RECORD, 16'd0);
    put_rec_hdr(HANDSHAKE_RECORD, 16'd2);
    put_noise(2);
    put_hello_record(CLIENT_HELLO);
    flush_buffer(1'b1);
    // Messages that overrun their record, one with the largest length.
    put_rec_hdr(HANDSHAKE_RECORD, 16'd10);
    put_hs_msg(CLIENT_HELLO, 24'd40, 6);
    put_rec_hdr(HANDSHAKE_RECORD, 16'd8);
    put_hs_msg(CLIENT_HELLO, 24'hFFFFFF, 4);
    put_hello_record(CLIENT_HELLO);
    flush_buffer(1'b1);
    // Short matching body, empty message, other type, then a long hello
    // whose tail is skipped; bytes after the capture are ignored.
    put_rec_hdr(HANDSHAKE_RECORD, 16'd106);
    put_hs_msg(CLIENT_HELLO, 24'd10, 10);
    put_hs_msg(CLIENT_HELLO, 24'd0, 0);
    put_hs_msg(SERVER_HELLO, 24'd40, 40);
    put_hs_msg(CLIENT_HELLO, 24'd40, 40);
    put_noise(7);
    flush_buffer(1'b1);

    write_wanted(SERVER_HELLO);
    put_rec_hdr(HANDSHAKE_RECORD, 16'(2 * (MIN_BODY + 4)));
    put_hs_msg(CLIENT_HELLO, 24'(MIN_BODY), MIN_BODY);
    put_hs_msg(SERVER_HELLO, 24'(MIN_BODY), MIN_BODY);
    flush_buffer(1'b1);

    // wanted_type changes between two messages of one record.
    put_rec_hdr(HANDSHAKE_RECORD, 16'(2 * (MIN_BODY + 4)));
    put_hs_msg(CLIENT_HELLO, 24'(MIN_BODY), MIN_BODY);
    flush_buffer(1'b0);
    write_wanted(CLIENT_HELLO);
    put_hs_msg(CLIENT_HELLO, 24'(MIN_BODY), MIN_BODY);
    flush_buffer(1'b1);

    write_wanted(8'h00);
    put_hello_record(8'h00);
    flush_buffer(1'b1);
    write_wanted(8'hFF);
    put_rec_hdr(HANDSHAKE_RECORD, 16'hFFFF);
    put_hs_msg(8'hFF, 24'(MIN_BODY), MIN_BODY);
    flush_buffer(1'b1);
    put_hello_record(8'hFF);
    flush_buffer(1'b1);

    wait_idle();
    hold_at = acc_cnt + 25;
    calm_lo = hold_at + 100;
    calm_hi = hold_at + 400;

    rnd_bytes = 0;
    nbuf = 0;
    while (rnd_bytes < 110 || nbuf < 10) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: v = CLIENT_HELLO;
          1: v = SERVER_HELLO;
          2: v = 8'h00;
          3: v = 8'hFF;
          default: v = 8'($urandom_range(255));
        endcase
        write_wanted(v);
      end
      kind = $urandom_range(99);
      if (kind < 15) begin
        put_noise($urandom_range(12, 1));
        if ($urandom_range(1) == 0) bytes_q[0] = HANDSHAKE_RECORD;
      end else begin
        nrec = $urandom_range(3, 1);
        hello_at = $urandom_range(nrec - 1);
        for (int i = 0; i < nrec; i++) begin
          if (i != hello_at && $urandom_range(4) == 0) begin
            rtype = 8'($urandom_range(255));
            if (rtype == HANDSHAKE_RECORD) rtype = APP_DATA_REC;
            n = $urandom_range(8);
            put_rec_hdr(rtype, 16'(n));
            put_noise(n);
          end else begin
            put_hs_record(i == hello_at, want_m);
          end
        end
        // Now and then break the well-formed buffer.
        brk = $urandom_range(99);
        if (brk < 10) begin
          n = $urandom_range(8, 1);
          while (n > 0 && bytes_q.size() > 1) begin
            void'(bytes_q.pop_back());
            n--;
          end
        end else if (brk < 20) begin
          put_noise($urandom_range(6, 1));
        end else if (brk < 25) begin
          bytes_q[$urandom_range(bytes_q.size() - 1)] = 8'($urandom_range(255));
        end
      end
      rnd_bytes += bytes_q.size();
      nbuf++;
      flush_buffer(1'b1);
    end

    @(negedge clk);
    while (byte_q.size() != 0 || in_ch.valid || random_exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errs == 0) begin
      $display("tls_hello_random_extractor_unit: match");
    end else begin
      $display("tls_hello_random_extractor_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: tls_hello_random_extractor_unit.f
sv/tlsh_pkg.sv
sv/tlsh_if.sv
sv/tlsh_ram.sv
sv/tls_hello_random_extractor_unit.sv
tb/sv/testbench.sv
